/* rtl/rgp_pkg.sv */
`default_nettype none

package rgp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int CFG_WIDTH       = 31;
	localparam int CFG_ADDR_W      = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_GM  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DT  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ESC = 2'd2;

	localparam logic [CFG_WIDTH-1:0] GM_RESET  = 31'd41529;
	localparam logic [CFG_WIDTH-1:0] DT_RESET  = 31'd655;
	localparam logic [CFG_WIDTH-1:0] ESC_RESET = 31'd6553600;

	function automatic int accel_latency(input int w, input int f);
		return w + f + 5;
	endfunction

endpackage

`default_nettype wire

/* rtl/rgp_delay.sv */
`default_nettype none

module rgp_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] data_q [0:DEPTH-1];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= DEPTH'({valid_q, in_valid});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q[0] <= in_data;
			for (int k = 1; k < DEPTH; k++) begin
				data_q[k] <= data_q[k-1];
			end
		end
	end

	assign out_valid = valid_q[DEPTH-1];
	assign out_data  = data_q[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/rgp_accel.sv */
`default_nettype none

module rgp_accel import rgp_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [CFG_WIDTH-1:0] gm,
	input  logic [2:0][W-1:0]    pos,
	output logic [2:0][W-1:0]    acc,
	output logic                 sat
);

	localparam int SW   = 2 * W;
	localparam int DW   = CFG_WIDTH + 2 * F;
	localparam int CMPW = (DW > 3 * W) ? DW + 1 : 3 * W + 1;
	localparam int DFW  = (DW > W) ? DW : W;
	localparam int RW   = W + 3;
	localparam int UW   = F + 1;
	localparam int KW   = W - 1;
	localparam int MW   = KW + UW;

	logic [DFW-1:0] d_full;
	assign d_full = DFW'({gm, {(2*F){1'b0}}});

	logic [2:0][W-1:0]  mag_c;
	logic [2:0][W-1:0]  mag_s1;
	logic [2:0]         neg_s1;
	logic [2:0][SW-1:0] sq_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = pos[i][W-1] ? (~pos[i] + W'(1)) : pos[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= pos[i][W-1];
				sq_s1[i]  <= SW'(mag_c[i]) * SW'(mag_c[i]);
			end
		end
	end

	logic [SW-1:0]     s_c;
	logic [SW-1:0]     s_s2;
	logic [SW-1:0]     kr_s2;
	logic              zero_s2;
	logic              ovk_s2;
	logic [2:0][W-1:0] mag_s2;
	logic [2:0]        neg_s2;

	assign s_c = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= s_c;
			zero_s2 <= (s_c == '0);
			ovk_s2  <= ((CMPW'(gm) << (2 * F)) >= (CMPW'(s_c) << (W - 1)));
			kr_s2   <= SW'((CMPW'(gm) << (2 * F)) >> (W - 1));
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
		end
	end

	logic [SW-1:0]     s_s3    [0:W];
	logic [W-1:0]      rt_s3   [0:W];
	logic [RW-1:0]     rm_s3   [0:W];
	logic [SW-1:0]     kr_s3   [0:W];
	logic [KW-1:0]     kq_s3   [0:W];
	logic [2:0][W-1:0] mag_s3  [0:W];
	logic [2:0]        neg_s3  [0:W];
	logic              zero_s3 [0:W];
	logic              ovk_s3  [0:W];

	assign s_s3[0]    = s_s2;
	assign rt_s3[0]   = '0;
	assign rm_s3[0]   = '0;
	assign kr_s3[0]   = kr_s2;
	assign kq_s3[0]   = '0;
	assign mag_s3[0]  = mag_s2;
	assign neg_s3[0]  = neg_s2;
	assign zero_s3[0] = zero_s2;
	assign ovk_s3[0]  = ovk_s2;

	for (genvar j = 0; j < W; j++) begin : g_root
		logic [RW-1:0] rem2;
		logic [RW-1:0] trial;
		logic [SW:0]   kr2;
		logic          kbit;
		logic [SW-1:0] kr_n;
		logic [KW-1:0] kq_n;

		assign rem2  = {rm_s3[j][RW-3:0], s_s3[j][SW-1-2*j -: 2]};
		assign trial = RW'({rt_s3[j], 2'b01});

		if (j < W - 1) begin : g_div
			assign kr2  = {kr_s3[j], d_full[W-2-j]};
			assign kbit = (kr2 >= {1'b0, s_s3[j]});
			assign kr_n = kbit ? SW'(kr2 - {1'b0, s_s3[j]}) : kr2[SW-1:0];
			assign kq_n = KW'({kq_s3[j], kbit});
		end else begin : g_hold
			assign kr2  = '0;
			assign kbit = 1'b0;
			assign kr_n = kr_s3[j];
			assign kq_n = kq_s3[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem2 >= trial) begin
					rm_s3[j+1] <= rem2 - trial;
					rt_s3[j+1] <= {rt_s3[j][W-2:0], 1'b1};
				end else begin
					rm_s3[j+1] <= rem2;
					rt_s3[j+1] <= {rt_s3[j][W-2:0], 1'b0};
				end
				s_s3[j+1]    <= s_s3[j];
				kr_s3[j+1]   <= kr_n;
				kq_s3[j+1]   <= kq_n;
				mag_s3[j+1]  <= mag_s3[j];
				neg_s3[j+1]  <= neg_s3[j];
				zero_s3[j+1] <= zero_s3[j];
				ovk_s3[j+1]  <= ovk_s3[j];
			end
		end
	end

	logic [W-1:0]       r_s4    [0:UW];
	logic [KW-1:0]      k_s4    [0:UW];
	logic [2:0][W-1:0]  ur_s4   [0:UW];
	logic [2:0][UW-1:0] uq_s4   [0:UW];
	logic [2:0][W-1:0]  mag_s4  [0:UW];
	logic [2:0]         neg_s4  [0:UW];
	logic               zero_s4 [0:UW];
	logic               ovk_s4  [0:UW];

	assign r_s4[0]    = rt_s3[W];
	assign k_s4[0]    = kq_s3[W];
	assign mag_s4[0]  = mag_s3[W];
	assign neg_s4[0]  = neg_s3[W];
	assign zero_s4[0] = zero_s3[W];
	assign ovk_s4[0]  = ovk_s3[W];
	assign uq_s4[0]   = '0;

	for (genvar i = 0; i < 3; i++) begin : g_urem
		assign ur_s4[0][i] = mag_s3[W][i] >> 1;
	end

	for (genvar t = 0; t < UW; t++) begin : g_unit
		logic [2:0][W:0] urem2;
		logic [2:0]      ubit;

		for (genvar i = 0; i < 3; i++) begin : g_lane
			if (t == 0) begin : g_first
				assign urem2[i] = {ur_s4[t][i], mag_s4[t][i][0]};
			end else begin : g_rest
				assign urem2[i] = {ur_s4[t][i], 1'b0};
			end
			assign ubit[i] = (urem2[i] >= {1'b0, r_s4[t]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					ur_s4[t+1][i] <= ubit[i] ? W'(urem2[i] - {1'b0, r_s4[t]})
					                         : urem2[i][W-1:0];
					uq_s4[t+1][i] <= UW'({uq_s4[t][i], ubit[i]});
				end
				r_s4[t+1]    <= r_s4[t];
				k_s4[t+1]    <= k_s4[t];
				mag_s4[t+1]  <= mag_s4[t];
				neg_s4[t+1]  <= neg_s4[t];
				zero_s4[t+1] <= zero_s4[t];
				ovk_s4[t+1]  <= ovk_s4[t];
			end
		end
	end

	logic [KW-1:0]      k_eff;
	logic [2:0][MW-1:0] prod_s5;
	logic [2:0]         neg_s5;
	logic               zero_s5;
	logic               ovk_s5;

	assign k_eff = ovk_s4[UW] ? {KW{1'b1}} : k_s4[UW];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= MW'(k_eff) * MW'(uq_s4[UW][i]);
			end
			neg_s5  <= neg_s4[UW];
			zero_s5 <= zero_s4[UW];
			ovk_s5  <= ovk_s4[UW];
		end
	end

	logic [2:0][W-1:0] m_c;
	logic [2:0][W-1:0] a_c;
	logic [2:0]        msat_c;
	logic [2:0][W-1:0] acc_s6;
	logic              sat_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msat_c[i] = prod_s5[i][MW-1];
			m_c[i]    = msat_c[i] ? {1'b0, {(W-1){1'b1}}} : prod_s5[i][MW-1 -: W];
			a_c[i]    = zero_s5 ? '0 : (neg_s5[i] ? m_c[i] : (~m_c[i] + W'(1)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6 <= a_c;
			sat_s6 <= zero_s5 | ovk_s5 | (|msat_c);
		end
	end

	assign acc = acc_s6;
	assign sat = sat_s6;

endmodule

`default_nettype wire

/* rtl/rk4_gravity_particle_step.sv */
// One RK4 step of a particle under a central point-mass pull, fully pipelined.
//
// Config: write gm_product (0), time_step (1) or escape_radius (2) through
// cfg_we / cfg_addr / cfg_wdata while no particle is in flight.
// Input stream (s_*): one beat per particle, twelve signed Q fields in s_tdata.
// Output stream (m_*): one beat per particle in the same order: six signed
// Q fields in m_tdata, the escape and saturation flags in m_tuser.
//
// Throughput: one particle per cycle while the output is not stalled. Each
// of the four force evaluations runs a bit-per-stage square root in
// parallel with a bit-per-stage division for gm/r^2, then a bit-per-stage
// division for the unit vector; those chains set the depth.
//
// Reset clears the config registers to their defaults and drops every
// valid bit; data in flight is lost. When m_tready is low while a result
// is held, the whole pipeline freezes and s_tready drops; nothing is lost
// or repeated.
`default_nettype none

module rk4_gravity_particle_step import rgp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
	input  logic [CFG_WIDTH-1:0]                   cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, start_pos_x, start_pos_y,
	// start_pos_z, start_vel_x, start_vel_y, start_vel_z
	input  logic [((12*VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [((6*VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,
	// was_reset, saturated
	output logic [1:0]                             m_tuser
);

	localparam int W      = VALUE_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int AW     = W + 3;
	localparam int PW     = W + CFG_WIDTH + 1;
	localparam int PBW    = AW + F + 1;
	localparam int CW     = PW + F + 4;
	localparam int SW     = 2 * W;
	localparam int EW     = (SW > 2 * CFG_WIDTH) ? SW : 2 * CFG_WIDTH;
	localparam int LA     = accel_latency(W, F);
	localparam int OUT_DW = ((6 * W + 7) / 8) * 8;
	localparam logic [F:0] ONE6 = (F+1)'(((64'd1 << F) + 64'd3) / 64'd6);
	localparam logic signed [CW-1:0] VMAXC = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [CW-1:0] VMINC = ~VMAXC;

	typedef struct packed {
		logic [2:0][W-1:0]  x;
		logic [2:0][W-1:0]  v;
		logic [2:0][W-1:0]  sp;
		logic [2:0][W-1:0]  sv;
		logic [2:0][AW-1:0] ax;
		logic [2:0][AW-1:0] av;
		logic               sat;
	} bund_t;

	function automatic logic [W:0] clampv(input logic signed [CW-1:0] a);
		if (a > VMAXC) begin
			return {1'b1, VMAXC[W-1:0]};
		end else if (a < VMINC) begin
			return {1'b1, VMINC[W-1:0]};
		end
		return {1'b0, a[W-1:0]};
	endfunction

	function automatic logic [W:0] addq(input logic [W-1:0] base, input logic [PW-1:0] prod);
		logic [W:0] t;
		logic [W:0] r;
		t = clampv(CW'($signed(prod)) >>> F);
		r = clampv(CW'($signed(base)) + CW'($signed(t[W-1:0])));
		return {t[W] | r[W], r[W-1:0]};
	endfunction

	function automatic bund_t seg_acc(input bund_t b, input logic [2:0][W-1:0] dx,
	                                  input logic [2:0][W-1:0] dv, input logic two,
	                                  input logic s);
		bund_t o;
		o = b;
		o.sat = b.sat | s;
		for (int i = 0; i < 3; i++) begin
			o.ax[i] = b.ax[i] + (two ? (AW'($signed(dx[i])) << 1) : AW'($signed(dx[i])));
			o.av[i] = b.av[i] + (two ? (AW'($signed(dv[i])) << 1) : AW'($signed(dv[i])));
		end
		return o;
	endfunction

	logic [CFG_WIDTH-1:0] gm_q;
	logic [CFG_WIDTH-1:0] dt_q;
	logic [CFG_WIDTH-1:0] er_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm_q <= GM_RESET;
			dt_q <= DT_RESET;
			er_q <= ESC_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GM:  gm_q <= cfg_wdata;
				REG_DT:  dt_q <= cfg_wdata;
				REG_ESC: er_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	bund_t             seg_b  [0:4];
	logic [2:0][W-1:0] seg_dx [0:4];
	logic [2:0][W-1:0] seg_dv [0:4];
	logic              seg_v  [0:4];

	bund_t in_b;

	always_comb begin
		in_b = '0;
		for (int i = 0; i < 3; i++) begin
			in_b.x[i]  = s_tdata[i*W +: W];
			in_b.v[i]  = s_tdata[(3+i)*W +: W];
			in_b.sp[i] = s_tdata[(6+i)*W +: W];
			in_b.sv[i] = s_tdata[(9+i)*W +: W];
		end
	end

	assign seg_b[0]  = in_b;
	assign seg_dx[0] = in_b.v;
	assign seg_dv[0] = '0;
	assign seg_v[0]  = s_tvalid;

	for (genvar g = 0; g < 4; g++) begin : g_seg
		logic [CFG_WIDTH-1:0] h;
		bund_t                b_s1;
		logic [2:0][W-1:0]    dx_s1;
		logic [2:0][PW-1:0]   px_s1;
		logic [2:0][PW-1:0]   pv_s1;
		logic                 v_s1;
		bund_t                b_s2;
		logic [2:0][W-1:0]    xs_s2;
		logic [2:0][W-1:0]    odx_s2;
		logic                 v_s2;
		logic [2:0][W-1:0]    acc_o;
		logic                 asat_o;
		bund_t                b_d;
		logic [2:0][W-1:0]    odx_d;
		logic                 v_d;
		logic [2:0][W:0]      xq_c;
		logic [2:0][W:0]      vq_c;
		bund_t                b_c;

		assign h = (g == 3) ? dt_q : (dt_q >> 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else if (en) begin
				v_s1 <= seg_v[g];
				v_s2 <= v_s1;
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				xq_c[i] = addq(b_s1.x[i], px_s1[i]);
				vq_c[i] = addq(b_s1.v[i], pv_s1[i]);
			end
			b_c = b_s1;
			if (g != 0) begin
				b_c.sat = b_s1.sat | xq_c[0][W] | xq_c[1][W] | xq_c[2][W]
				        | vq_c[0][W] | vq_c[1][W] | vq_c[2][W];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				b_s1  <= seg_b[g];
				dx_s1 <= seg_dx[g];
				for (int i = 0; i < 3; i++) begin
					px_s1[i] <= PW'($signed(seg_dx[g][i])) * PW'($signed({1'b0, h}));
					pv_s1[i] <= PW'($signed(seg_dv[g][i])) * PW'($signed({1'b0, h}));
				end
				b_s2 <= b_c;
				if (g == 0) begin
					xs_s2  <= b_s1.x;
					odx_s2 <= dx_s1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						xs_s2[i]  <= xq_c[i][W-1:0];
						odx_s2[i] <= vq_c[i][W-1:0];
					end
				end
			end
		end

		rgp_accel #(.W(W), .F(F)) u_accel (
			.clk (clk),
			.en  (en),
			.gm  (gm_q),
			.pos (xs_s2),
			.acc (acc_o),
			.sat (asat_o)
		);

		rgp_delay #(.WIDTH($bits(bund_t) + 3 * W), .DEPTH(LA)) u_delay (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s2),
			.in_data   ({b_s2, odx_s2}),
			.out_valid (v_d),
			.out_data  ({b_d, odx_d})
		);

		assign seg_b[g+1]  = seg_acc(b_d, odx_d, acc_o, (g == 1) || (g == 2), asat_o);
		assign seg_dx[g+1] = odx_d;
		assign seg_dv[g+1] = acc_o;
		assign seg_v[g+1]  = v_d;
	end

	bund_t               fin_b_s1;
	logic [2:0][PBW-1:0] bx_s1;
	logic [2:0][PBW-1:0] bv_s1;
	bund_t               fin_b_s2;
	logic [2:0][W-1:0]   px_s2;
	logic [2:0][W-1:0]   pv_s2;
	bund_t               fin_b_s3;
	logic [2:0][PW-1:0]  qx_s3;
	logic [2:0][PW-1:0]  qv_s3;
	bund_t               fin_b_s4;
	logic [2:0][W-1:0]   xn_s4;
	logic [2:0][W-1:0]   vn_s4;
	bund_t               fin_b_s5;
	logic [2:0][W-1:0]   xn_s5;
	logic [2:0][W-1:0]   vn_s5;
	logic [2:0][SW-1:0]  sq_s5;
	logic [2*CFG_WIDTH-1:0] er2_s5;
	logic [5:1]          fin_v;

	logic [2:0][W:0]     pxc;
	logic [2:0][W:0]     pvc;
	logic [2:0][W:0]     xnc;
	logic [2:0][W:0]     vnc;
	logic [2:0][W-1:0]   magn;
	bund_t               fin_b2_c;
	bund_t               fin_b4_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pxc[i]  = clampv(CW'($signed(bx_s1[i])) >>> F);
			pvc[i]  = clampv(CW'($signed(bv_s1[i])) >>> F);
			xnc[i]  = addq(fin_b_s3.x[i], qx_s3[i]);
			vnc[i]  = addq(fin_b_s3.v[i], qv_s3[i]);
			magn[i] = xn_s4[i][W-1] ? (~xn_s4[i] + W'(1)) : xn_s4[i];
		end
		fin_b2_c     = fin_b_s1;
		fin_b2_c.sat = fin_b_s1.sat | pxc[0][W] | pxc[1][W] | pxc[2][W]
		             | pvc[0][W] | pvc[1][W] | pvc[2][W];
		fin_b4_c     = fin_b_s3;
		fin_b4_c.sat = fin_b_s3.sat | xnc[0][W] | xnc[1][W] | xnc[2][W]
		             | vnc[0][W] | vnc[1][W] | vnc[2][W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v <= '0;
		end else if (en) begin
			fin_v <= {fin_v[4:1], seg_v[4]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_b_s1 <= seg_b[4];
			for (int i = 0; i < 3; i++) begin
				bx_s1[i] <= PBW'($signed(seg_b[4].ax[i])) * PBW'($signed({1'b0, ONE6}));
				bv_s1[i] <= PBW'($signed(seg_b[4].av[i])) * PBW'($signed({1'b0, ONE6}));
			end

			fin_b_s2 <= fin_b2_c;
			for (int i = 0; i < 3; i++) begin
				px_s2[i] <= pxc[i][W-1:0];
				pv_s2[i] <= pvc[i][W-1:0];
			end

			fin_b_s3 <= fin_b_s2;
			for (int i = 0; i < 3; i++) begin
				qx_s3[i] <= PW'($signed(px_s2[i])) * PW'($signed({1'b0, dt_q}));
				qv_s3[i] <= PW'($signed(pv_s2[i])) * PW'($signed({1'b0, dt_q}));
			end

			fin_b_s4 <= fin_b4_c;
			for (int i = 0; i < 3; i++) begin
				xn_s4[i] <= xnc[i][W-1:0];
				vn_s4[i] <= vnc[i][W-1:0];
			end

			fin_b_s5 <= fin_b_s4;
			xn_s5    <= xn_s4;
			vn_s5    <= vn_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SW'(magn[i]) * SW'(magn[i]);
			end
			er2_s5 <= (2*CFG_WIDTH)'(er_q) * (2*CFG_WIDTH)'(er_q);
		end
	end

	logic [SW-1:0]     ssum_c;
	logic              esc_c;
	logic [OUT_DW-1:0] od_c;
	logic [OUT_DW-1:0] out_data_q;
	logic [1:0]        out_user_q;

	assign ssum_c = sq_s5[0] + sq_s5[1] + sq_s5[2];
	assign esc_c  = EW'(ssum_c) > EW'(er2_s5);

	always_comb begin
		od_c = '0;
		for (int i = 0; i < 3; i++) begin
			od_c[i*W +: W]     = esc_c ? fin_b_s5.sp[i] : xn_s5[i];
			od_c[(3+i)*W +: W] = esc_c ? fin_b_s5.sv[i] : vn_s5[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fin_v[5];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= od_c;
			out_user_q <= {fin_b_s5.sat, esc_c};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire

/* rtl/rgp_chk.sv */
`default_nettype none

module rgp_chk import rgp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((6*VALUE_WIDTH+7)/8)*8-1:0]  m_tdata,
	input logic [1:0]                          m_tuser
);

	localparam int LAT = 4 * (accel_latency(VALUE_WIDTH, FRAC_BITS) + 2) + 6;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output register");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline is frozen");

	a_no_early: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result beat right after reset, pipeline depth is " , LAT);

endmodule

bind rk4_gravity_particle_step rgp_chk #(
	.VALUE_WIDTH (VALUE_WIDTH),
	.FRAC_BITS   (FRAC_BITS)
) u_rgp_chk (.*);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import rgp_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam int IN_W = ((12 * VW + 7) / 8) * 8;
	localparam int OUT_W = ((6 * VW + 7) / 8) * 8;
	localparam longint VMAX = 64'sh7fffffff;
	localparam longint VMIN = -VMAX - 1;
	localparam longint ONE_SIXTH = 10923;
	localparam logic [CFG_WIDTH-1:0] CFG_MAX = '1;

	typedef struct {
		longint c[3];
	} vec3_t;

	typedef struct {
		logic [OUT_W-1:0] data;
		logic [1:0]       flags;
	} particle_out_t;

	class particle_scoreboard;
		longint unsigned gm;
		longint unsigned dt;
		longint unsigned esc;
		bit sat;
		particle_out_t pending[$];
		int errors;

		function new();
			gm = GM_RESET;
			dt = DT_RESET;
			esc = ESC_RESET;
			errors = 0;
		endfunction

		function longint clampq(longint v);
			if (v > VMAX) begin
				sat = 1;
				return VMAX;
			end
			if (v < VMIN) begin
				sat = 1;
				return VMIN;
			end
			return v;
		endfunction

		function longint qmul(longint a, longint b);
			return clampq((a * b) >>> 16);
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function longint unsigned isqrt(longint unsigned s);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > s) bitv >>= 2;
			while (bitv != 0) begin
				if (s >= res + bitv) begin
					s -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint unsigned sumsq(vec3_t p);
			longint unsigned s;
			s = 0;
			for (int i = 0; i < 3; i++) s += mag(p.c[i]) * mag(p.c[i]);
			return s;
		endfunction

		function vec3_t pull(vec3_t p);
			vec3_t a;
			longint unsigned s, r, k, u, m;
			s = sumsq(p);
			if (s == 0) begin
				sat = 1;
				for (int i = 0; i < 3; i++) a.c[i] = 0;
				return a;
			end
			r = isqrt(s);
			k = (gm << 32) / s;
			if (k > VMAX) begin
				sat = 1;
				k = VMAX;
			end
			for (int i = 0; i < 3; i++) begin
				u = (mag(p.c[i]) << 16) / r;
				m = (k * u) >> 16;
				if (m > VMAX) begin
					sat = 1;
					m = VMAX;
				end
				a.c[i] = p.c[i] < 0 ? longint'(m) : -longint'(m);
			end
			return a;
		endfunction

		function void rk_stage(vec3_t x0, vec3_t v0, vec3_t dx, vec3_t dv, longint h,
				output vec3_t odx, output vec3_t odv);
			vec3_t xs;
			for (int i = 0; i < 3; i++) begin
				xs.c[i] = clampq(x0.c[i] + qmul(dx.c[i], h));
				odx.c[i] = clampq(v0.c[i] + qmul(dv.c[i], h));
			end
			odv = pull(xs);
		endfunction

		function longint weigh(longint a, longint b, longint c, longint d);
			longint s;
			s = a + 2 * (b + c) + d;
			return clampq((s * ONE_SIXTH) >>> 16);
		endfunction

		function particle_out_t advance(logic [IN_W-1:0] d);
			particle_out_t r;
			vec3_t x, v, dxa, dva, dxb, dvb, dxc, dvc, dxd, dvd, xn, vn;
			longint h, h2, px, pv;
			bit escaped;
			sat = 0;
			h = dt;
			h2 = dt >> 1;
			for (int i = 0; i < 3; i++) begin
				x.c[i] = longint'($signed(d[VW*i +: VW]));
				v.c[i] = longint'($signed(d[VW*(3+i) +: VW]));
			end
			dxa = v;
			dva = pull(x);
			rk_stage(x, v, dxa, dva, h2, dxb, dvb);
			rk_stage(x, v, dxb, dvb, h2, dxc, dvc);
			rk_stage(x, v, dxc, dvc, h, dxd, dvd);
			for (int i = 0; i < 3; i++) begin
				px = weigh(dxa.c[i], dxb.c[i], dxc.c[i], dxd.c[i]);
				pv = weigh(dva.c[i], dvb.c[i], dvc.c[i], dvd.c[i]);
				xn.c[i] = clampq(x.c[i] + qmul(px, h));
				vn.c[i] = clampq(v.c[i] + qmul(pv, h));
			end
			escaped = sumsq(xn) > esc * esc;
			r.data = '0;
			for (int i = 0; i < 3; i++) begin
				r.data[VW*i +: VW] = escaped ? d[VW*(6+i) +: VW] : xn.c[i][VW-1:0];
				r.data[VW*(3+i) +: VW] = escaped ? d[VW*(9+i) +: VW] : vn.c[i][VW-1:0];
			end
			r.flags = {sat, escaped};
			return r;
		endfunction

		function void note_particle(logic [IN_W-1:0] d);
			pending.push_back(advance(d));
		endfunction

		function void check_result(logic [OUT_W-1:0] d, logic [1:0] flags);
			particle_out_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h %b", d, flags);
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 6; i++)
				if (d[VW*i +: VW] !== e.data[VW*i +: VW]) begin
					errors++;
					if (errors <= 10)
						$display("field %0d: expected %h got %h", i,
							e.data[VW*i +: VW], d[VW*i +: VW]);
				end
			if (flags[0] !== e.flags[0]) begin
				errors++;
				if (errors <= 10) $display("was_reset: expected %b got %b", e.flags[0], flags[0]);
			end
			if (flags[1] !== e.flags[1]) begin
				errors++;
				if (errors <= 10) $display("saturated: expected %b got %b", e.flags[1], flags[1]);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_WIDTH-1:0] cfg_wdata;
	logic s_tvalid, s_tready;
	// pos_x..z, vel_x..z, start_pos_x..z, start_vel_x..z
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid, m_tready;
	// new_pos_x..z, new_vel_x..z
	logic [OUT_W-1:0] m_tdata;
	// was_reset, saturated
	logic [1:0] m_tuser;

	particle_scoreboard sb = new();
	int idle_on = 1;
	int hold_req = 0;

	rk4_gravity_particle_step dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_particle(s_tdata);
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 36);
			end
		end
	end

	function automatic logic [VW-1:0] span(int r);
		return VW'(int'($urandom_range(2 * r)) - r);
	endfunction

	function automatic logic [IN_W-1:0] make_particle(int kind);
		logic [IN_W-1:0] d;
		int r;
		d = '0;
		for (int i = 0; i < 12; i++) d[VW*i +: VW] = $urandom;
		if (kind == 0) begin
			r = 32'h10000 << $urandom_range(0, 8);
			for (int i = 0; i < 3; i++) begin
				d[VW*i +: VW] = span(r);
				d[VW*(3+i) +: VW] = span(32'h10000 << $urandom_range(0, 6));
			end
		end else if (kind == 1) begin
			r = int'(sb.esc > 32'h3fffffff ? 32'h3fffffff : sb.esc);
			for (int i = 0; i < 3; i++) d[VW*(3+i) +: VW] = span(32'h1000);
			d[VW*0 +: VW] = VW'(r + int'($urandom_range(16)) - 8);
			d[VW*1 +: VW] = span(32'h100);
			d[VW*2 +: VW] = span(32'h100);
		end
		return d;
	endfunction

	function automatic logic [IN_W-1:0] uniform(logic [VW-1:0] p, logic [VW-1:0] v);
		logic [IN_W-1:0] d;
		d = '0;
		for (int i = 0; i < 3; i++) begin
			d[VW*i +: VW] = p;
			d[VW*(3+i) +: VW] = v;
			d[VW*(6+i) +: VW] = ~p;
			d[VW*(9+i) +: VW] = ~v;
		end
		return d;
	endfunction

	task automatic send_particle(logic [IN_W-1:0] d);
		while (idle_on && $urandom_range(99) < 36) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_WIDTH-1:0] gmv, logic [CFG_WIDTH-1:0] dtv,
			logic [CFG_WIDTH-1:0] escv);
		cfg_we <= 1; cfg_addr <= REG_GM; cfg_wdata <= gmv;
		@(posedge clk);
		sb.gm = gmv;
		cfg_addr <= REG_DT; cfg_wdata <= dtv;
		@(posedge clk);
		sb.dt = dtv;
		cfg_addr <= REG_ESC; cfg_wdata <= escv;
		@(posedge clk);
		sb.esc = escv;
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_run(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			send_particle(make_particle(k < 70 ? 0 : (k < 85 ? 1 : 2)));
		end
	endtask

	initial begin
		logic [CFG_WIDTH-1:0] settings [7][3];
		settings = '{
			'{GM_RESET, DT_RESET, ESC_RESET},
			'{CFG_MAX, CFG_MAX, CFG_MAX},
			'{'0, '0, '0},
			'{CFG_MAX, DT_RESET, '0},
			'{GM_RESET, CFG_MAX, ESC_RESET},
			'{31'd65536, 31'd6554, 31'd655360},
			'{31'd9830400, 31'd3277, 31'd32768000}
		};
		arst_n = 0;
		cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
		s_tvalid = 0; s_tdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_particle(uniform('0, '0));
		send_particle(uniform(32'h7fffffff, 32'h7fffffff));
		send_particle(uniform(32'h80000000, 32'h80000000));
		send_particle(uniform(32'h00010000, '0));
		send_particle(uniform(32'hffff0000, 32'h00010000));
		send_particle(uniform(32'h00000001, 32'hffffffff));
		send_particle(uniform(32'h00640000, '0));
		send_particle(uniform(32'h00640001, '0));
		send_particle(uniform(32'h7fffffff, 32'h80000000));
		send_particle(uniform(32'h55555555, 32'haaaaaaaa));
		for (int i = 0; i < 8; i++) send_particle(make_particle(i % 3));
		drain();

		idle_on = 0;
		hold_req = 600;
		random_run(400);
		idle_on = 1;
		random_run(200);
		drain();

		for (int p = 1; p < 9; p++) begin
			if (p < 7)
				write_cfg(settings[p][0], settings[p][1], settings[p][2]);
			else
				write_cfg(CFG_WIDTH'($urandom >> 1), CFG_WIDTH'($urandom_range(32'h20000)),
					CFG_WIDTH'($urandom >> 1));
			random_run(150);
			drain();
		end

		s_tvalid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
